// ===== rtl/csfr_pkg.sv =====
// shared types, constants and crc function for the setpoint frame receiver
`default_nettype none
package csfr_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_INIT    = 8'h00;
  localparam logic [3:0] PAYLOAD_LEN = 4'd12;
  localparam logic [3:0] FRAME_LEN   = 4'd13;
  localparam logic [3:0] COUNT_MAX   = 4'd15;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_CRC = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  crc;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
  } result_t;

  // one byte of crc-8, msb first, unrolled into an xor network
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/csfr_frame_core.sv =====
// frame state: byte count, running crc, word staging and held setpoints
`default_nettype none
module csfr_frame_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output csfr_pkg::result_t     result
);
  import csfr_pkg::*;

  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] words_r [3];
  logic [31:0] words_nxt [3];
  logic [31:0] vx_r, vx_nxt;
  logic [31:0] vy_r, vy_nxt;
  logic [31:0] wz_r, wz_nxt;

  logic        in_payload;
  logic [1:0]  widx;
  logic [3:0]  cnt_inc;
  logic [7:0]  crc_upd;
  logic [31:0] words_upd [3];
  status_t     status;

  assign in_payload = (cnt_r < PAYLOAD_LEN);
  assign widx       = cnt_r[3:2];
  assign cnt_inc    = (cnt_r != COUNT_MAX) ? (cnt_r + 4'd1) : COUNT_MAX;
  assign crc_upd    = in_payload ? crc8_byte(crc_r, data_byte) : crc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      words_upd[i] = words_r[i];
    end
    if (in_payload) begin
      words_upd[widx][{cnt_r[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  always_comb begin
    if (cnt_inc != FRAME_LEN) begin
      status = ST_LEN;
    end else if (data_byte != crc_upd) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    vx_nxt  = vx_r;
    vy_nxt  = vy_r;
    wz_nxt  = wz_r;
    for (int i = 0; i < 3; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (step) begin
      if (last_byte) begin
        // restart for the next frame
        cnt_nxt = 4'd0;
        crc_nxt = CRC_INIT;
        for (int i = 0; i < 3; i++) begin
          words_nxt[i] = '0;
        end
        if (status == ST_OK) begin
          vx_nxt = words_upd[0];
          vy_nxt = words_upd[1];
          wz_nxt = words_upd[2];
        end
      end else begin
        cnt_nxt = cnt_inc;
        crc_nxt = crc_upd;
        for (int i = 0; i < 3; i++) begin
          words_nxt[i] = words_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      crc_r <= CRC_INIT;
      vx_r  <= '0;
      vy_r  <= '0;
      wz_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      wz_r  <= wz_nxt;
      for (int i = 0; i < 3; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

  // result as seen at a last byte, holds already updated on ok
  assign result.status = status;
  assign result.crc    = crc_upd;
  assign result.vx     = (status == ST_OK) ? words_upd[0] : vx_r;
  assign result.vy     = (status == ST_OK) ? words_upd[1] : vy_r;
  assign result.wz     = (status == ST_OK) ? words_upd[2] : wz_r;

endmodule
`default_nettype wire

// ===== rtl/crc8_setpoint_frame_receiver_top.sv =====
// top level of the crc-8 checked setpoint frame receiver
`default_nettype none
// receives a frame one byte per transaction, last_byte marking its end. a good
// frame is 13 bytes: three little-endian 32-bit setpoint words (vx, vy, wz)
// followed by a crc-8 (poly 0x07, init 0, msb first, no reflection, no final
// xor) over the first twelve bytes. each last byte yields exactly one result
// transaction with status 0 ok, 1 wrong length, 2 crc mismatch, the computed
// crc and the held setpoints, which change only on an ok frame; other bytes
// yield nothing. throughput is one byte per cycle: the byte crc is a single
// xor network between the input register and the result register. a last
// byte reaches result valid through the input register, then the result
// register. the input register keeps accepting while a result waits to be
// taken; only a last byte that finds the result register still full holds
// the pipe.
module crc8_setpoint_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_computed_crc,
  output logic [31:0]      out_vx_bits,
  output logic [31:0]      out_vy_bits,
  output logic [31:0]      out_wz_bits
);
  import csfr_pkg::*;

  // input register
  logic       ivld_r, ivld_nxt;
  logic [7:0] ibyte_r;
  logic       ilast_r;

  // result register
  logic       ovld_r, ovld_nxt;
  result_t    ores_r;

  result_t    core_res;
  logic       adv;
  logic       in_xact;

  // a registered byte moves on unless it is a last byte and the result slot is full
  assign adv      = ivld_r && (!ilast_r || !ovld_r || out_ready);
  assign in_ready = !ivld_r || adv;
  assign in_xact  = in_valid && in_ready;

  assign ivld_nxt = in_xact || (ivld_r && !adv);
  assign ovld_nxt = (adv && ilast_r) || (ovld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      ivld_r <= ivld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xact) begin
      ibyte_r <= in_data_byte;
      ilast_r <= in_last_byte;
    end
    if (adv && ilast_r) begin
      ores_r <= core_res;
    end
  end

  csfr_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (ibyte_r),
    .last_byte (ilast_r),
    .result    (core_res)
  );

  assign out_valid        = ovld_r;
  assign out_status       = ores_r.status;
  assign out_computed_crc = ores_r.crc;
  assign out_vx_bits      = ores_r.vx;
  assign out_vy_bits      = ores_r.vy;
  assign out_wz_bits      = ores_r.wz;

endmodule
`default_nettype wire

// ===== bench/tb_crc8_setpoint_frame_receiver_top.sv =====
// testbench for the crc-8 checked setpoint frame receiver: frame stimulus, predictor, checks
module tb_crc8_setpoint_frame_receiver_top;
  import csfr_pkg::*;

  // predicts each result from the accepted bytes and checks the results in order
  class setpoint_scoreboard;
    logic [3:0]  frame_count;
    logic [7:0]  frame_crc;
    logic [31:0] staged [3];
    logic [31:0] vx_hold;
    logic [31:0] vy_hold;
    logic [31:0] wz_hold;
    result_t     awaited_results[$];
    int          mismatches;

    function new();
      mismatches = 0;
      vx_hold    = '0;
      vy_hold    = '0;
      wz_hold    = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_count = '0;
      frame_crc   = CRC_INIT;
      staged[0]   = '0;
      staged[1]   = '0;
      staged[2]   = '0;
    endfunction

    // msb-first crc-8 over one byte
    function logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
    endfunction

    // one accepted byte; a last byte yields one expected result
    function void take_byte(input logic [7:0] b, input logic last);
      logic [3:0]  pos;
      logic [31:0] word;
      result_t     r;
      pos = frame_count;
      if (pos < PAYLOAD_LEN) begin
        frame_crc = crc8_step(frame_crc, b);
        word = staged[pos[3:2]];
        word[{pos[1:0], 3'b000} +: 8] = b;
        staged[pos[3:2]] = word;
      end
      frame_count = (pos < COUNT_MAX) ? pos + 4'd1 : COUNT_MAX;
      if (last) begin
        if (frame_count != FRAME_LEN) begin
          r.status = ST_LEN;
        end else if (b != frame_crc) begin
          r.status = ST_CRC;
        end else begin
          r.status = ST_OK;
          vx_hold  = staged[0];
          vy_hold  = staged[1];
          wz_hold  = staged[2];
        end
        r.crc = frame_crc;
        r.vx  = vx_hold;
        r.vy  = vy_hold;
        r.wz  = wz_hold;
        awaited_results.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got status %0d crc %h",
                 $time, got.status, got.crc);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.crc != want.crc) begin
          $display("%0t computed_crc: expected %h, got %h", $time, want.crc, got.crc);
          mismatches++;
        end
        if (got.vx != want.vx) begin
          $display("%0t vx_bits: expected %h, got %h", $time, want.vx, got.vx);
          mismatches++;
        end
        if (got.vy != want.vy) begin
          $display("%0t vy_bits: expected %h, got %h", $time, want.vy, got.vy);
          mismatches++;
        end
        if (got.wz != want.wz) begin
          $display("%0t wz_bits: expected %h, got %h", $time, want.wz, got.wz);
          mismatches++;
        end
      end
    endfunction
  endclass

  // how frame payload bytes are filled
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_ALTERNATE
  } fill_t;

  localparam int BYTE_TARGET = 1350;
  localparam int PHASES      = 8;
  localparam int DRAIN_CYCLES = 8;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_computed_crc;
  logic [31:0] out_vx_bits;
  logic [31:0] out_vy_bits;
  logic [31:0] out_wz_bits;

  // percent of cycles in which the sender idles or the receiver stalls
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int bytes_sent         = 0;

  setpoint_scoreboard sb;
  result_t            seen;

  crc8_setpoint_frame_receiver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_vx_bits      (out_vx_bits),
    .out_vy_bits      (out_vy_bits),
    .out_wz_bits      (out_wz_bits)
  );

  // 8 unit period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: values read right after the edge are the ones the edge sampled,
  // so a transaction is taken exactly when valid and ready were both high
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.status = status_t'(out_status);
      seen.crc    = out_computed_crc;
      seen.vx     = out_vx_bits;
      seen.vy     = out_vy_bits;
      seen.wz     = out_wz_bits;
      sb.check_result(seen);
    end
    // one ready decision per edge, so ready is never dropped and raised in one step
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b, last);
    bytes_sent++;
  endtask

  // a frame of len bytes; byte 12, when there is one, carries the crc of bytes 0..11,
  // flipped by a nonzero mask when a crc error is wanted
  task automatic send_frame(input int len, input fill_t fill, input bit bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      if (i == 12) begin
        b = crc;
        if (bad_crc) b = b ^ 8'($urandom_range(255, 1));
      end else begin
        case (fill)
          FILL_ZERO:      b = 8'h00;
          FILL_ONES:      b = 8'hff;
          FILL_ALTERNATE: b = i[0] ? 8'hff : 8'h00;
          default:        b = 8'($urandom_range(255));
        endcase
      end
      if (i < 12) crc = sb.crc8_step(crc, b);
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int    phase;
    int    pick;
    fill_t fill;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: good frame of 00/ff bytes, a one-byte frame, a crc error
    send_frame(13, FILL_ALTERNATE, 1'b0);
    send_frame(1, FILL_ONES, 1'b0);
    send_frame(13, FILL_RANDOM, 1'b1);

    // random frames, cycling through the idle/stall mixes
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
      endcase
      while (bytes_sent < (phase + 1) * BYTE_TARGET / PHASES) begin
        case ($urandom_range(15))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_ONES;
          2:       fill = FILL_ALTERNATE;
          default: fill = FILL_RANDOM;
        endcase
        pick = $urandom_range(99);
        // mostly well-formed frames, then crc errors, short and long frames
        if (pick < 60)      send_frame(13, fill, 1'b0);
        else if (pick < 75) send_frame(13, fill, 1'b1);
        else if (pick < 87) send_frame($urandom_range(12, 1), fill, 1'b0);
        else                send_frame($urandom_range(20, 14), fill, 1'($urandom_range(1)));
      end
    end
    in_valid <= 1'b0;

    // drain, then give a stray result a chance to show up
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
